// ===== rtl/core/helicity_bank_decoder_predictor_assert.svh =====
// ---------------------------------------------------------------------------
// helicity_bank_decoder_predictor_assert.svh
// Assertion macros shared by the helicity bank decoder blocks.
// ---------------------------------------------------------------------------
`ifndef HELICITY_BANK_DECODER_PREDICTOR_ASSERT_SVH
`define HELICITY_BANK_DECODER_PREDICTOR_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define HBDP_ASSERT(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// Implication checked at the same edge.
`define HBDP_ASSERT_IMPL(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/hbdp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hbdp_pkg
// Types, codes and the LFSR step shared by the helicity bank decoder blocks.
// ---------------------------------------------------------------------------
package hbdp_pkg;

    localparam logic [4:0] MIN_BANK_WORDS = 5'd18;

    localparam logic [3:0] TYPE_DECODER = 4'd8;
    localparam logic [3:0] TYPE_FILLER  = 4'd15;

    // capture slots within a decoder block (index after the header)
    localparam logic [5:0] CAP_SEED    = 6'd0;
    localparam logic [5:0] CAP_CNT_LO  = 6'd1;
    localparam logic [5:0] CAP_CNT_HI  = 6'd4;
    localparam logic [5:0] CAP_STATUS  = 6'd9;
    localparam logic [5:0] CAP_HISTORY = 6'd13;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_FAIL  = 2'd2;

    localparam logic [1:0] HEL_MINUS   = 2'd0;
    localparam logic [1:0] HEL_PLUS    = 2'd1;
    localparam logic [1:0] HEL_UNKNOWN = 2'd2;

    localparam int OUT_BITS = 208;

    // one finished bank, handed from front to back
    typedef struct packed {
        logic             short_bank;
        logic             check_ok;
        logic [31:0]      seed;
        logic [9:0]       status_bits;   // 9:2 phase, 1 polarity, 0 stable
        logic [3:0][31:0] counters;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // 30-bit XOR LFSR, one step
    function automatic logic [29:0] lfsr_step(input logic [29:0] s);
        logic fb;
        fb = s[6] ^ s[27] ^ s[28] ^ s[29];
        return {s[28:0], fb};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hbdp_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hbdp_front
// Word parser: tracks types, captures decoder words, checks the history.
// ---------------------------------------------------------------------------
module hbdp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic          in_ready,
    input  wire logic [31:0]   in_word,
    input  wire logic          in_last,
    output hbdp_pkg::job_t     job,
    output logic               push
);

    logic [3:0]       prev_type_reg, prev_type_next;
    logic [5:0]       cap_idx_reg, cap_idx_next;
    logic [5:0]       cap_cnt_reg, cap_cnt_next;
    logic [4:0]       seen_reg, seen_next;
    logic [31:0]      seed_reg, seed_next;
    logic [31:0]      hist_reg, hist_next;
    logic [9:0]       stat_reg, stat_next;
    logic [3:0][31:0] cnt_reg, cnt_next;

    logic             accept;
    logic [5:0]       slot;
    logic [5:0]       cnt_sel;
    logic [3:0]       wtype;
    logic [29:0]      predicted;

    assign accept  = in_valid & in_ready;
    assign push    = accept & in_last;
    assign slot    = cap_idx_reg - 6'd1;
    assign cnt_sel = slot - 6'd1;

    always_comb begin
        prev_type_next = prev_type_reg;
        cap_idx_next   = cap_idx_reg;
        cap_cnt_next   = cap_cnt_reg;
        seen_next      = seen_reg;
        seed_next      = seed_reg;
        hist_next      = hist_reg;
        stat_next      = stat_reg;
        cnt_next       = cnt_reg;
        wtype          = in_word[31] ? in_word[30:27] : prev_type_reg;

        if (accept) begin
            if (cap_idx_reg != 6'd0) begin
                unique case (slot) inside
                    hbdp_pkg::CAP_SEED:    seed_next = in_word;
                    [hbdp_pkg::CAP_CNT_LO:hbdp_pkg::CAP_CNT_HI]:
                                           cnt_next[cnt_sel[1:0]] = in_word;
                    hbdp_pkg::CAP_STATUS:  stat_next = {in_word[15:8], in_word[5], in_word[0]};
                    hbdp_pkg::CAP_HISTORY: hist_next = in_word;
                    default: ;
                endcase
                if (cap_idx_reg < cap_cnt_reg) begin
                    cap_idx_next = cap_idx_reg + 6'd1;
                end else begin
                    cap_idx_next = 6'd0;
                    cap_cnt_next = 6'd1;
                end
            end else begin
                if (wtype == hbdp_pkg::TYPE_DECODER) begin
                    cap_cnt_next = in_word[5:0];
                    cap_idx_next = 6'd1;
                end
                prev_type_next = wtype;
            end
            if (seen_reg < hbdp_pkg::MIN_BANK_WORDS) begin
                seen_next = seen_reg + 5'd1;
            end
        end
    end

    // history check: upper 30 bits stepped twice must match lower 30 bits
    assign predicted = hbdp_pkg::lfsr_step(hbdp_pkg::lfsr_step(hist_next[31:2]));

    always_comb begin
        job.short_bank  = seen_next < hbdp_pkg::MIN_BANK_WORDS;
        job.check_ok    = hist_next[29:0] == predicted;
        job.seed        = seed_next;
        job.status_bits = stat_next;
        job.counters    = cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            prev_type_reg <= hbdp_pkg::TYPE_FILLER;
            cap_idx_reg   <= 6'd0;
            cap_cnt_reg   <= 6'd1;
            seen_reg      <= 5'd0;
            seed_reg      <= 32'd0;
            hist_reg      <= 32'd0;
            stat_reg      <= 10'd0;
            cnt_reg       <= '0;
        end else begin
            prev_type_reg <= prev_type_next;
            cap_idx_reg   <= cap_idx_next;
            cap_cnt_reg   <= cap_cnt_next;
            seen_reg      <= seen_next;
            seed_reg      <= seed_next;
            hist_reg      <= hist_next;
            stat_reg      <= stat_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hbdp_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hbdp_queue
// Small FIFO of finished banks between parser and predictor.
// ---------------------------------------------------------------------------
module hbdp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire hbdp_pkg::job_t wr_job,
    input  wire logic           pop,
    output hbdp_pkg::job_t      rd_job,
    output hbdp_pkg::qstat_t    stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbdp_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] level_reg, level_next;
    logic             do_push, do_pop;

    assign stat.empty = level_reg == CNT_W'(0);
    assign stat.full  = level_reg == CNT_W'(DEPTH);
    assign do_push    = push & ~stat.full;
    assign do_pop     = pop & ~stat.empty;
    assign rd_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            level_next = level_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hbdp_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hbdp_back
// Predictor: steps the seed by the delay and builds the result transaction.
// ---------------------------------------------------------------------------
module hbdp_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [7:0]                    delay,
    input  wire hbdp_pkg::job_t                job,
    input  wire logic                          q_empty,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [hbdp_pkg::OUT_BITS-1:0]      m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    hbdp_pkg::job_t                 job_reg;
    logic [29:0]                    seed_reg, seed_next;
    logic [7:0]                     step_reg, step_next;
    logic                           valid_reg, valid_next;
    logic [hbdp_pkg::OUT_BITS-1:0]  data_reg;
    logic [hbdp_pkg::OUT_BITS-1:0]  data_new;
    logic                           done, load;
    logic [1:0]                     res_status, res_hel;
    logic [29:0]                    res_seed;

    assign pop  = (state_reg == ST_IDLE) && !q_empty;
    assign done = (state_reg == ST_STEP) && (step_reg == delay);
    assign load = done && (!valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        seed_next  = seed_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    seed_next  = job.seed[29:0];
                    step_next  = 8'd0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!done) begin
                    seed_next = hbdp_pkg::lfsr_step(seed_reg);
                    step_next = step_reg + 8'd1;
                end else if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result fields
    always_comb begin
        if (job_reg.short_bank) begin
            res_status = hbdp_pkg::STATUS_SHORT;
            res_hel    = hbdp_pkg::HEL_UNKNOWN;
            res_seed   = 30'd0;
        end else if (!job_reg.check_ok) begin
            res_status = hbdp_pkg::STATUS_FAIL;
            res_hel    = hbdp_pkg::HEL_UNKNOWN;
            res_seed   = 30'd0;
        end else begin
            res_status = hbdp_pkg::STATUS_OK;
            res_seed   = seed_reg;
            if (!job_reg.status_bits[0]) begin
                res_hel = hbdp_pkg::HEL_UNKNOWN;
            end else if (seed_reg[0] ^ job_reg.status_bits[1]) begin
                res_hel = hbdp_pkg::HEL_PLUS;
            end else begin
                res_hel = hbdp_pkg::HEL_MINUS;
            end
        end
        if (job_reg.short_bank) begin
            data_new = {{(hbdp_pkg::OUT_BITS - 4){1'b0}}, res_hel, res_status};
        end else begin
            data_new = {4'd0,
                        job_reg.counters[3], job_reg.counters[2],
                        job_reg.counters[1], job_reg.counters[0],
                        job_reg.status_bits[0], job_reg.status_bits[1],
                        job_reg.status_bits[9:2], job_reg.seed,
                        res_seed, res_hel, res_status};
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= job;
        end
        if (load) begin
            data_reg <= data_new;
        end
        seed_reg <= seed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 8'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/helicity_bank_decoder_predictor.sv =====
// Path: a bank's last word pushes it into the queue; the predictor pops it, steps the seed by
//   helicity_delay and registers the result. Throughput: one bank word per cycle while the
//   two-bank queue has room; the back end takes one bank at a time (one LFSR step a cycle), so
//   banks that arrive faster than it finishes them fill the queue and stall input until a slot frees.
// Reset: synchronous, active low; clears parser state, queue, predictor FSM and the output
//   valid flag, and sets helicity_delay to 0.
`default_nettype none
// ---------------------------------------------------------------------------
// helicity_bank_decoder_predictor
// Parses one helicity decoder bank per frame and reports the predicted helicity.
// ---------------------------------------------------------------------------
`include "helicity_bank_decoder_predictor_assert.svh"
module helicity_bank_decoder_predictor #(
    parameter int QUEUE_DEPTH = 2           // banks buffered between parser and predictor
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // bank words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // [31:0] word
    input  wire logic                          s_tlast,   // last word of bank
    // helicity_delay register
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [7:0]                    cfg_data,
    // results
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [3:2] helicity, [33:4] true_seed, [65:34] reported_seed,
    // [73:66] pattern_phase, [74] event_polarity, [75] stable_bit,
    // [107:76] stable_fall_count, [139:108] stable_rise_count,
    // [171:140] pattern_sync_count, [203:172] pair_sync_count, [207:204] zero
    output logic [hbdp_pkg::OUT_BITS-1:0]      m_tdata
);

    logic [7:0]         delay_reg;
    hbdp_pkg::job_t     front_job;
    hbdp_pkg::job_t     queue_job;
    hbdp_pkg::qstat_t   qstat;
    logic               push, pop;

    // config write is always taken; it is to be changed only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= 8'd0;
        end else if (cfg_valid) begin
            delay_reg <= cfg_data;
        end
    end

    // front stalls only when the queue holds no free slot for a finished bank
    assign s_tready = ~qstat.full;

    hbdp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_word  (s_tdata),
        .in_last  (s_tlast),
        .job      (front_job),
        .push     (push)
    );

    hbdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_job  (front_job),
        .pop     (pop),
        .rd_job  (queue_job),
        .stat    (qstat)
    );

    // back end: seed stepping and output register
    hbdp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .delay    (delay_reg),
        .job      (queue_job),
        .q_empty  (qstat.empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ---- checks ----
    `HBDP_ASSERT(a_queue_flags, aclk, aresetn, !(qstat.empty && qstat.full), "queue empty and full")
    `HBDP_ASSERT_IMPL(a_no_lost_bank, aclk, aresetn, push, s_tready, "bank pushed into full queue")
    `HBDP_ASSERT_IMPL(a_bad_unknown, aclk, aresetn, m_tvalid && (m_tdata[1:0] != hbdp_pkg::STATUS_OK), (m_tdata[3:2] == hbdp_pkg::HEL_UNKNOWN) && (m_tdata[33:4] == 30'd0), "failed bank with helicity or seed")
    `HBDP_ASSERT_IMPL(a_short_zero, aclk, aresetn, m_tvalid && (m_tdata[1:0] == hbdp_pkg::STATUS_SHORT), m_tdata[207:4] == '0, "short bank with captured data")

endmodule
`default_nettype wire
